### sv/relocating_image_loader_assert.svh
// ----------------------------------------------------------------------------
// Relocating image loader assertion macros
// Short forms for clocked implication checks under the block reset.
// ----------------------------------------------------------------------------
`ifndef RELOCATING_IMAGE_LOADER_ASSERT_SVH
`define RELOCATING_IMAGE_LOADER_ASSERT_SVH

// same-cycle implication
`define RIL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("relocating image loader check failed");

// next-cycle implication
`define RIL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("relocating image loader check failed");

`endif

### sv/ril_pkg.sv
// ----------------------------------------------------------------------------
// Relocating image loader package
// Sizes, codes and the job record handed from the parser to the result stage.
// ----------------------------------------------------------------------------
package ril_pkg;

	localparam int WORD_BYTES  = 4;
	localparam int TABLE_DEPTH = 64;

	localparam int WORD_W  = 8 * WORD_BYTES;
	localparam int BEAT_W  = $clog2(WORD_BYTES);
	localparam int FILL_W  = $clog2(WORD_BYTES + 1);
	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ADDR_W  = 32;
	localparam int ENTRY_W = 32;
	localparam int LEN_W   = 5;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] HDR_LEN_MASK   = 8'h1F;
	localparam logic [7:0] HDR_CLASS_MASK = 8'hE0;

	localparam logic CMD_STREAM = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

	typedef enum logic [1:0] {
		FX_NONE   = 2'd0,
		FX_ORIGIN = 2'd1,
		FX_LIMIT  = 2'd2,
		FX_LINK   = 2'd3
	} fix_class_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_LINK  = 2'd2
	} status_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		JOB_IDLE = 2'd0,
		JOB_PASS = 2'd1,
		JOB_WORD = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic               use_table;
		logic [WORD_W-1:0]  word;
		logic [ADDR_W-1:0]  address;
		status_t            status;
		logic               installed;
	} job_t;

endpackage

### sv/relocating_image_loader.sv
// ----------------------------------------------------------------------------
// Relocating image loader
// Parses a relocatable byte stream, applies word fix-ups, emits byte writes.
// ----------------------------------------------------------------------------
// Latency: the first result of an item is offered the cycle after acceptance.
// Throughput: one item per cycle while the result side does not stall; an item
//   that completes a held word gives WORD_BYTES beats, and the next item waits for the last of them.
// Link lookups come from a registered synchronous table read taken at accept.
// Reset (arst_n, asynchronous) clears parser state, registers and the result
//   stage at once; the link table is not cleared and is valid once loaded.
module relocating_image_loader (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ril_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ril_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            command,
	input  logic [7:0]                      stream_byte,
	input  logic [5:0]                      table_index,
	input  logic [31:0]                     table_value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            write_valid,
	output logic [31:0]                     write_address,
	output logic [7:0]                      write_byte,
	output logic                            installed,
	output logic [1:0]                      status,
	output logic                            last
);

	logic [ril_pkg::ADDR_W-1:0]   origin_q, limit_q;
	ril_pkg::phase_t              phase_q, phase_d;
	logic [ril_pkg::LEN_W-1:0]    left_q, left_d;
	ril_pkg::fix_class_t          class_q, class_d;
	logic                         holding_q, holding_d;
	logic [ril_pkg::WORD_W-1:0]   word_q, word_d;
	logic [ril_pkg::FILL_W-1:0]   fill_q, fill_d;
	logic [ril_pkg::ADDR_W-1:0]   offset_q, offset_d;
	logic                         done_q, done_d;

	logic [ril_pkg::ENTRY_W-1:0]  link_mem [ril_pkg::TABLE_DEPTH];
	logic [ril_pkg::ENTRY_W-1:0]  link_rd_s1;
	logic [ril_pkg::IDX_W-1:0]    link_raddr;
	logic                         link_we;

	logic                         item_acc, emit_ready, is_stream;
	logic [ril_pkg::LEN_W-1:0]    hdr_len;
	logic [2:0]                   hdr_class;
	ril_pkg::fix_class_t          cls_eff;
	logic [ril_pkg::WORD_W-1:0]   word_next;
	logic                         word_done;
	logic [ril_pkg::ADDR_W-1:0]   base_addr;
	ril_pkg::job_t                job;

	assign item_stall = !emit_ready;
	assign item_acc   = item_valid && !item_stall;
	assign is_stream  = (command == ril_pkg::CMD_STREAM) && !done_q;

	assign hdr_len   = ril_pkg::LEN_W'(stream_byte & ril_pkg::HDR_LEN_MASK);
	assign hdr_class = 3'((stream_byte & ril_pkg::HDR_CLASS_MASK) >> 5);
	// classes four to seven carry no fix-up
	assign cls_eff   = hdr_class[2] ? ril_pkg::FX_NONE : ril_pkg::fix_class_t'(hdr_class[1:0]);
	assign base_addr = origin_q + offset_q;
	assign word_done = (fill_q == ril_pkg::FILL_W'(ril_pkg::WORD_BYTES - 1));

	always_comb begin
		word_next = word_q;
		for (int k = 0; k < ril_pkg::WORD_BYTES; k++) begin
			if (fill_q == ril_pkg::FILL_W'(k)) begin
				word_next[8*k +: 8] = stream_byte;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			limit_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ril_pkg::REG_ORIGIN: origin_q <= cfg_data;
				ril_pkg::REG_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser next state
	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		class_d   = class_q;
		holding_d = holding_q;
		word_d    = word_q;
		fill_d    = fill_q;
		offset_d  = offset_q;
		done_d    = done_q;
		if (item_acc && is_stream) begin
			case (phase_q)
				ril_pkg::PH_HEADER: begin
					if (stream_byte == 8'd0) begin
						done_d = 1'b1;
					end else begin
						class_d   = cls_eff;
						left_d    = hdr_len;
						word_d    = '0;
						fill_d    = '0;
						holding_d = (cls_eff != ril_pkg::FX_NONE) &&
							(hdr_len >= ril_pkg::LEN_W'(ril_pkg::WORD_BYTES));
						if (hdr_len != '0) begin
							phase_d = ril_pkg::PH_BODY;
						end
					end
				end
				ril_pkg::PH_BODY: begin
					left_d = left_q - ril_pkg::LEN_W'(1);
					if (left_q == ril_pkg::LEN_W'(1)) begin
						phase_d = ril_pkg::PH_HEADER;
					end
					if (holding_q) begin
						word_d = word_next;
						fill_d = fill_q + ril_pkg::FILL_W'(1);
						if (word_done) begin
							holding_d = 1'b0;
							offset_d  = offset_q + ril_pkg::ADDR_W'(ril_pkg::WORD_BYTES);
						end
					end else begin
						offset_d = offset_q + ril_pkg::ADDR_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// parser outputs: result job, table port
	always_comb begin
		job.kind      = ril_pkg::JOB_IDLE;
		job.use_table = 1'b0;
		job.word      = '0;
		job.address   = '0;
		job.status    = ril_pkg::ST_OK;
		job.installed = done_d;
		link_we       = item_acc && (command == ril_pkg::CMD_LOAD) &&
			(ril_pkg::WORD_W'(table_index) < ril_pkg::WORD_W'(ril_pkg::TABLE_DEPTH));
		link_raddr    = ril_pkg::IDX_W'(word_next);
		if (is_stream) begin
			case (phase_q)
				ril_pkg::PH_HEADER: begin
					if (stream_byte != 8'd0 && hdr_len == '0 &&
						cls_eff != ril_pkg::FX_NONE) begin
						job.status = ril_pkg::ST_SHORT;
					end
				end
				ril_pkg::PH_BODY: begin
					if (holding_q) begin
						if (word_done) begin
							job.kind    = ril_pkg::JOB_WORD;
							job.address = base_addr;
							job.word    = word_next;
							case (class_q)
								ril_pkg::FX_ORIGIN:
									job.word = word_next + ril_pkg::WORD_W'(origin_q);
								ril_pkg::FX_LIMIT:
									job.word = word_next + ril_pkg::WORD_W'(limit_q);
								ril_pkg::FX_LINK: begin
									if (word_next < ril_pkg::WORD_W'(ril_pkg::TABLE_DEPTH)) begin
										job.use_table = 1'b1;
									end else begin
										job.status = ril_pkg::ST_LINK;
									end
								end
								default: ;
							endcase
						end
					end else begin
						job.kind    = ril_pkg::JOB_PASS;
						job.address = base_addr;
						job.word    = ril_pkg::WORD_W'(stream_byte);
						if (class_q != ril_pkg::FX_NONE &&
							fill_q < ril_pkg::FILL_W'(ril_pkg::WORD_BYTES)) begin
							job.status = ril_pkg::ST_SHORT;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ril_pkg::PH_HEADER;
			left_q    <= '0;
			class_q   <= ril_pkg::FX_NONE;
			holding_q <= 1'b0;
			word_q    <= '0;
			fill_q    <= '0;
			offset_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			left_q    <= left_d;
			class_q   <= class_d;
			holding_q <= holding_d;
			word_q    <= word_d;
			fill_q    <= fill_d;
			offset_q  <= offset_d;
			done_q    <= done_d;
		end
	end

	// link table: loads and lookups both happen at accept, so order is kept
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[ril_pkg::IDX_W'(table_index)] <= table_value;
		end
		if (item_acc) begin
			link_rd_s1 <= link_mem[link_raddr];
		end
	end

	ril_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (item_acc),
		.job           (job),
		.link_data     (link_rd_s1),
		.ready         (emit_ready),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_byte    (write_byte),
		.installed     (installed),
		.status        (status),
		.last          (last)
	);

	`include "relocating_image_loader_assert.svh"

	`RIL_ASSERT_NEXT(a_burst_holds, result_valid && !result_stall && !last, result_valid)
	`RIL_ASSERT_NEXT(a_done_sticky, done_q, done_q)
	`RIL_ASSERT_NOW(a_burst_writes, result_valid && !last, write_valid)
	`RIL_ASSERT_NOW(a_link_on_write, result_valid && status == ril_pkg::ST_LINK, write_valid)

endmodule

### sv/ril_emit.sv
// ----------------------------------------------------------------------------
// Relocating image loader result stage
// Holds one job and plays it out as one beat, or one beat per word byte.
// ----------------------------------------------------------------------------
module ril_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ril_pkg::job_t                 job,
	input  logic [ril_pkg::ENTRY_W-1:0]   link_data,
	output logic                          ready,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          write_valid,
	output logic [ril_pkg::ADDR_W-1:0]    write_address,
	output logic [7:0]                    write_byte,
	output logic                          installed,
	output logic [1:0]                    status,
	output logic                          last
);

	logic                          valid_q;
	ril_pkg::job_t                 job_s1;
	logic [ril_pkg::BEAT_W-1:0]    beat_q;
	logic [ril_pkg::ADDR_W-1:0]    addr_q;
	logic [ril_pkg::WORD_W-1:0]    word_sel;
	logic                          beat_acc;

	assign word_sel = job_s1.use_table ? ril_pkg::WORD_W'(link_data) : job_s1.word;
	assign last = (job_s1.kind != ril_pkg::JOB_WORD) ||
		(beat_q == ril_pkg::BEAT_W'(ril_pkg::WORD_BYTES - 1));
	assign beat_acc = valid_q && !result_stall;
	assign ready = !valid_q || (beat_acc && last);

	assign result_valid  = valid_q;
	assign write_valid   = (job_s1.kind != ril_pkg::JOB_IDLE);
	assign write_address = addr_q;
	assign write_byte    = word_sel[8*beat_q +: 8];
	assign installed     = job_s1.installed;
	assign status        = job_s1.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (beat_acc) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + ril_pkg::BEAT_W'(1);
			end
		end
	end

	// payload: advance the byte address on each non-final beat
	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
			addr_q <= job.address;
		end else if (beat_acc && !last) begin
			addr_q <= addr_q + ril_pkg::ADDR_W'(1);
		end
	end

endmodule

### tb/loader_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocating image loader checker
// Sits beside the loader and watches its register port and both channels.
// Each accepted input beat advances a private copy of the parser, the word
// fix-up logic and the link table, and queues the write beats it should give.
// Each accepted result beat is compared with the oldest queued write beat.
// ----------------------------------------------------------------------------
module loader_checker
	import ril_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  logic                 command,
	input  logic [7:0]           stream_byte,
	input  logic [5:0]           table_index,
	input  logic [31:0]          table_value,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic                 write_valid,
	input  logic [31:0]          write_address,
	input  logic [7:0]           write_byte,
	input  logic                 installed,
	input  logic [1:0]           status,
	input  logic                 last,
	output int                   mismatches,
	output int                   writes_due
);

	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              inst;
		status_t           st;
		logic              fin;
	} write_beat_t;

	write_beat_t pending_writes [$];

	logic [ADDR_W-1:0]  origin;
	logic [ADDR_W-1:0]  limit;
	phase_t             phase;
	logic [LEN_W-1:0]   bytes_left;
	fix_class_t         fclass;
	logic [WORD_W-1:0]  word_buf;
	int                 word_fill;
	logic [ADDR_W-1:0]  offset;
	logic [ENTRY_W-1:0] link_entry [TABLE_DEPTH];
	logic               done;
	logic               holding;

	assign writes_due = pending_writes.size();

	function automatic void note_beat(logic wr, logic [ADDR_W-1:0] addr, logic [7:0] data,
			status_t st, logic fin);
		write_beat_t b;
		b = '{wr, addr, data, done, st, fin};
		pending_writes.push_back(b);
	endfunction

	function automatic void take_body_byte();
		bytes_left = bytes_left - LEN_W'(1);
		if (bytes_left == '0) begin
			phase = PH_HEADER;
		end
	endfunction

	// apply the record's fix-up to the held word and write it out, low byte first
	function automatic void release_word();
		logic [WORD_W-1:0] w;
		status_t           st;
		w  = word_buf;
		st = ST_OK;
		case (fclass)
			FX_ORIGIN: begin
				w = w + origin;
			end
			FX_LIMIT: begin
				w = w + limit;
			end
			FX_LINK: begin
				if (w < TABLE_DEPTH) begin
					w = link_entry[w[IDX_W-1:0]];
				end else begin
					st = ST_LINK;
				end
			end
			default: begin
			end
		endcase
		for (int k = 0; k < WORD_BYTES; k++) begin
			note_beat(1'b1, origin + offset, w[8*k +: 8], st, k == WORD_BYTES - 1);
			offset = offset + ADDR_W'(1);
		end
	endfunction

	function automatic void advance_loader(logic cmd, logic [7:0] b, logic [5:0] idx,
			logic [31:0] val);
		logic [7:0] cls;
		status_t    st;
		if (cmd == CMD_LOAD) begin
			if (idx < TABLE_DEPTH) begin
				link_entry[idx] = val;
			end
			note_beat(1'b0, '0, '0, ST_OK, 1'b1);
			return;
		end
		// once installed, stream beats are ignored
		if (done) begin
			note_beat(1'b0, '0, '0, ST_OK, 1'b1);
			return;
		end
		if (phase == PH_HEADER) begin
			if (b == 8'h00) begin
				done = 1'b1;
				note_beat(1'b0, '0, '0, ST_OK, 1'b1);
				return;
			end
			cls        = (b & HDR_CLASS_MASK) >> 5;
			fclass     = (cls <= FX_LINK) ? fix_class_t'(cls[1:0]) : FX_NONE;
			bytes_left = LEN_W'(b & HDR_LEN_MASK);
			word_buf   = '0;
			word_fill  = 0;
			holding    = (fclass != FX_NONE) && (bytes_left >= WORD_BYTES);
			if (bytes_left == '0) begin
				note_beat(1'b0, '0, '0, (fclass != FX_NONE) ? ST_SHORT : ST_OK, 1'b1);
				return;
			end
			phase = PH_BODY;
			note_beat(1'b0, '0, '0, ST_OK, 1'b1);
			return;
		end
		if (holding) begin
			word_buf[8*word_fill +: 8] = b;
			word_fill++;
			take_body_byte();
			if (word_fill >= WORD_BYTES) begin
				holding = 1'b0;
				release_word();
			end else begin
				note_beat(1'b0, '0, '0, ST_OK, 1'b1);
			end
			return;
		end
		// pass-through byte; a fix-up record too short for a word is flagged
		st = (fclass != FX_NONE && word_fill < WORD_BYTES) ? ST_SHORT : ST_OK;
		note_beat(1'b1, origin + offset, b, st, 1'b1);
		offset = offset + ADDR_W'(1);
		take_body_byte();
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		write_beat_t got;
		write_beat_t want;
		if (!arst_n) begin
			mismatches = 0;
			origin     = '0;
			limit      = '0;
			phase      = PH_HEADER;
			bytes_left = '0;
			fclass     = FX_NONE;
			word_buf   = '0;
			word_fill  = 0;
			offset     = '0;
			done       = 1'b0;
			holding    = 1'b0;
			pending_writes.delete();
		end else begin
			if (result_valid && !result_stall) begin
				got = '{write_valid, write_address, write_byte, installed, status_t'(status),
					last};
				if (pending_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected write beat: wr=%0b addr=%h byte=%h inst=%0b st=%0d last=%0b",
							got.wr, got.addr, got.data, got.inst, got.st, got.fin);
					end
				end else begin
					want = pending_writes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("write beat mismatch at %0t", $realtime);
							$display("  expected wr=%0b addr=%h byte=%h inst=%0b st=%0d last=%0b",
								want.wr, want.addr, want.data, want.inst, want.st, want.fin);
							$display("  actual   wr=%0b addr=%h byte=%h inst=%0b st=%0d last=%0b",
								got.wr, got.addr, got.data, got.inst, got.st, got.fin);
						end
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ORIGIN) begin
					origin = cfg_data;
				end else if (cfg_index == REG_LIMIT) begin
					limit = cfg_data;
				end
			end
			if (item_valid && !item_stall) begin
				advance_loader(command, stream_byte, table_index, table_value);
			end
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relocating image loader testbench
// Feeds one relocatable image through the loader: link table loads, records
// of every fix-up class and length, short records, out-of-range link words
// and finally the end header, with random gaps on input and random stalls on
// output. Origin and limit are changed between phases while the block is idle.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import ril_pkg::*;

	localparam int CYCLE_LIMIT     = 250_000;
	localparam int ITEMS_PER_PHASE = 64;
	localparam int PHASES          = 6;
	localparam int MAX_GAP         = 17;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	logic                 command      = CMD_STREAM;
	logic [7:0]           stream_byte  = '0;
	logic [5:0]           table_index  = '0;
	logic [31:0]          table_value  = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 write_valid;
	logic [31:0]          write_address;
	logic [7:0]           write_byte;
	logic                 installed;
	logic [1:0]           status;
	logic                 last;
	int                   mismatches;
	int                   writes_due;

	int cycles      = 0;
	int items_sent  = 0;
	bit steady      = 1'b0;
	bit entry_loaded [TABLE_DEPTH] = '{default: 1'b0};

	relocating_image_loader dut (.*);

	loader_checker loader_check (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: draw a stall for every beat
	initial begin : sink
		int hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	task automatic send_item(input logic cmd, input logic [7:0] b, input logic [5:0] idx,
			input logic [31:0] val);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		stream_byte <= b;
		table_index <= idx;
		table_value <= val;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic stream(input logic [7:0] b);
		send_item(CMD_STREAM, b, 6'($urandom), $urandom);
	endtask

	task automatic load_entry(input logic [5:0] idx, input logic [31:0] val);
		entry_loaded[idx] = 1'b1;
		send_item(CMD_LOAD, 8'($urandom), idx, val);
	endtask

	// header, then the body; a fix-up word goes first, little-endian, if the record can hold one
	task automatic send_record(input logic [7:0] header, input logic [31:0] word,
			input bit allow_break);
		logic [2:0] cls;
		int         len;
		int         brk;
		cls = header[7:5];
		len = header[4:0];
		brk = -1;
		if (allow_break && len > 0 && $urandom_range(0, 7) == 0) begin
			brk = $urandom_range(0, len - 1);
		end
		stream(header);
		for (int k = 0; k < len; k++) begin
			// slip a table load into the body
			if (k == brk) begin
				load_entry(6'($urandom), $urandom);
			end
			if (cls != 3'(FX_NONE) && cls <= 3'(FX_LINK) && len >= WORD_BYTES
					&& k < WORD_BYTES) begin
				stream(word[8*k +: 8]);
			end else begin
				stream(8'($urandom));
			end
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (writes_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] origin_set [PHASES];
		logic [CFG_W-1:0] limit_set [PHASES];
		int               goal;
		int               pick;
		int               cdraw;
		logic [2:0]       cls;
		logic [4:0]       len;
		logic [5:0]       idx;
		logic [31:0]      word;

		origin_set = '{32'hFFFF_FFFC, 32'h0000_0000, 32'hFFFF_FFFF, $urandom,
			32'h8000_0000, $urandom};
		limit_set  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, $urandom,
			32'h0000_0001, $urandom};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!arst_n);

		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 2);
			if (ph > 0) begin
				settle();
			end
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORIGIN;
			cfg_data  <= origin_set[ph];
			@(posedge clk);
			cfg_index <= REG_LIMIT;
			cfg_data  <= limit_set[ph];
			@(posedge clk);
			// indexes past the last register must be ignored
			cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_LIMIT) + 1, (1 << CFG_IDX_W) - 1));
			cfg_data  <= $urandom;
			@(posedge clk);
			cfg_we    <= 1'b0;

			if (ph == 0) begin
				load_entry(6'd0, 32'hFFFF_FFFF);
				load_entry(6'd63, 32'h8000_0001);
				send_record(8'h24, 32'hFFFF_FFFF, 1'b0);
				send_record(8'h44, 32'h0000_0001, 1'b0);
				send_record(8'h64, 32'd63, 1'b0);
				send_record(8'h64, 32'h0000_0040, 1'b0);
				send_record(8'h62, 32'h0, 1'b0);
				stream(8'h20);
				send_record(8'hE1, 32'h0, 1'b0);
				send_record(8'h1F, 32'h0, 1'b0);
			end

			goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					load_entry(6'($urandom), $urandom);
				end else if (pick < 25) begin
					// empty records of every non-zero class
					stream({3'($urandom_range(1, 7)), 5'd0});
				end else begin
					cdraw = $urandom_range(0, 11);
					cls   = (cdraw > 7) ? 3'($urandom_range(1, 3)) : 3'(cdraw);
					len   = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 8))
						: 5'($urandom_range(0, 31));
					if (cls == 3'(FX_NONE) && len == 5'd0) begin
						len = 5'd1;
					end
					if (cls == 3'(FX_LINK) && $urandom_range(0, 2) != 0) begin
						// only loaded entries may be looked up
						do idx = 6'($urandom); while (!entry_loaded[idx]);
						word = 32'(idx);
					end else begin
						word = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
						if (cls == 3'(FX_LINK) && word < TABLE_DEPTH) begin
							word = word + TABLE_DEPTH;
						end
					end
					send_record({cls, len}, word, 1'b1);
				end
			end
		end

		// end of image, then beats that must be ignored
		stream(8'h00);
		stream(8'h24);
		stream(8'($urandom));
		load_entry(6'($urandom), $urandom);
		stream(8'h00);
		settle();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
